[src/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/prbd_pkg.sv]
// shared constants and types of the pulse rate beat detector
package prbd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int WINDOW      = 4;
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW);
  localparam int TIME_BITS   = 32;
  localparam int LIMIT_BITS  = 5;
  localparam int RATE_BITS   = 16;

  // 4*i0 + 3*i1 + 3*i2 needs four bits above the interval width
  localparam int DIV_BITS = TIME_BITS + 4;
  localparam int NUM_BITS = 20;

  localparam logic [LIMIT_BITS-1:0] COUNT_MAX   = '1;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd4;
  localparam logic [NUM_BITS-1:0]   RATE_NUMERATOR = 20'd600000;
  localparam logic [RATE_BITS-1:0]  RATE_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

[src/pulse_rate_beat_detector_core.sv]
// top level of the pulse rate beat detector
// Takes one averaged pulse sensor sample with its millisecond timestamp per
// request. A 4-sample moving sum is compared with the previous one; rising
// samples are counted (saturating at 31) and a beat is declared when the count
// first exceeds rise_limit (reset value 4) while not already rising. Each beat
// gives one result request: beat_interval, the ms since the previous beat
// (measured from time zero for the first), and beats_per_minute,
// floor(600000 / (4*i0 + 3*i1 + 3*i2)) saturating at 65535 (also for a zero
// divisor). A sample that declares no beat gives nothing and leaves the input
// open. A beat sample keeps the input stalled through the bit-serial weighted
// interval sum, the one-bit-per-cycle divider and the output load; the result
// then sits in the output register while the next sample can already be taken.
// rise_limit is written through rise_limit_we / rise_limit_data; the user must
// do so only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module pulse_rate_beat_detector_core import prbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // sample requests
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [TIME_BITS-1:0]   time_ms,
  // result requests
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [RATE_BITS-1:0]   beats_per_minute,
  output logic [TIME_BITS-1:0]   beat_interval,
  // configuration
  input  logic                   rise_limit_we,
  input  logic [LIMIT_BITS-1:0]  rise_limit_data
);

  state_t state, state_next;

  logic [LIMIT_BITS-1:0] rise_limit;
  logic [TIME_BITS-1:0]  last_beat_time;
  logic [TIME_BITS-1:0]  interval_one_back;
  logic [TIME_BITS-1:0]  interval_two_back;
  logic [TIME_BITS-1:0]  interval_now;

  logic                  accept;
  logic                  beat;
  logic                  start_sum;
  logic                  start_div;
  logic                  load_out;
  logic [DIV_BITS-1:0]   divisor;
  logic [RATE_BITS-1:0]  rate;
  unit_status_t          sum_status;
  unit_status_t          div_status;

  // requests are taken only while no beat is being worked on
  assign accept       = in_valid && !in_stall;
  assign interval_now = time_ms - last_beat_time;

  prbd_window u_window (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .sample     (sample),
    .rise_limit (rise_limit),
    .beat       (beat)
  );

  // intervals go in before they shift, so i1 and i2 are the two older ones
  prbd_wsum u_wsum (
    .clk     (clk),
    .rst     (rst),
    .start   (start_sum),
    .i0      (interval_now),
    .i1      (interval_one_back),
    .i2      (interval_two_back),
    .divisor (divisor),
    .status  (sum_status)
  );

  prbd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (start_div),
    .divisor (divisor),
    .rate    (rate),
    .status  (div_status)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && beat) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_status.done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait here only while an older result is still held
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    start_sum = 1'b0;
    start_div = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        start_sum = accept && beat;
      end
      ST_SUM: start_div = sum_status.done;
      ST_DIV: ;
      ST_OUT: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      rise_limit        <= LIMIT_RESET;
      last_beat_time    <= '0;
      interval_one_back <= '0;
      interval_two_back <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (rise_limit_we) begin
        rise_limit <= rise_limit_data;
      end
      // beat bookkeeping happens at the sample itself
      if (start_sum) begin
        last_beat_time    <= time_ms;
        interval_one_back <= interval_now;
        interval_two_back <= interval_one_back;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register, interval_one_back holds this beat's interval until the next beat
  always_ff @(posedge clk) begin
    if (load_out) begin
      beats_per_minute <= rate;
      beat_interval    <= interval_one_back;
    end
  end

  `CHECK_IMPLY(a_sum_done_in_sum, clk, rst, sum_status.done, state == ST_SUM, "sum done outside sum state")
  `CHECK_IMPLY(a_div_done_in_div, clk, rst, div_status.done, state == ST_DIV, "divide done outside divide state")
  `CHECK_IMPLY(a_busy_stalls, clk, rst, sum_status.busy || div_status.busy, in_stall, "input open while a unit is busy")
  `CHECK_NEXT(a_out_loaded, clk, rst, state == ST_OUT && !out_stall, out_valid && state == ST_IDLE, "result not loaded")

endmodule

[src/prbd_window.sv]
// sample window, rise counter and beat decision
module prbd_window import prbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [LIMIT_BITS-1:0]  rise_limit,
  output logic                   beat
);

  // tap 0 holds the newest sample, the last tap the oldest
  logic [SAMPLE_BITS-1:0] taps [WINDOW];
  logic [SUM_BITS-1:0]    window_sum;
  logic [SUM_BITS-1:0]    previous_sum;
  logic [LIMIT_BITS-1:0]  rise_counter;
  logic                   rising_flag;

  logic [SUM_BITS-1:0]   sum_next;
  logic [LIMIT_BITS-1:0] count_inc;
  logic                  rising;

  always_comb begin
    sum_next  = window_sum - SUM_BITS'(taps[WINDOW-1]) + SUM_BITS'(sample);
    rising    = sum_next > previous_sum;
    count_inc = (rise_counter == COUNT_MAX) ? COUNT_MAX : rise_counter + 1'b1;
    beat      = rising && !rising_flag && (count_inc > rise_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        taps[k] <= '0;
      end
      window_sum   <= '0;
      previous_sum <= '0;
      rise_counter <= '0;
      rising_flag  <= 1'b0;
    end else if (step) begin
      taps[0] <= sample;
      for (int k = 1; k < WINDOW; k++) begin
        taps[k] <= taps[k-1];
      end
      window_sum   <= sum_next;
      previous_sum <= sum_next;
      if (rising) begin
        rise_counter <= count_inc;
        if (beat) begin
          rising_flag <= 1'b1;
        end
      end else begin
        rise_counter <= '0;
        rising_flag  <= 1'b0;
      end
    end
  end

endmodule

[src/prbd_wsum.sv]
// bit-serial weighted interval sum 4*i0 + 3*i1 + 3*i2
module prbd_wsum import prbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] i0,
  input  logic [TIME_BITS-1:0] i1,
  input  logic [TIME_BITS-1:0] i2,
  output logic [DIV_BITS-1:0]  divisor,
  output unit_status_t         status
);

  localparam int CNT_BITS = $clog2(DIV_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DIV_BITS - 1);

  logic [TIME_BITS-1:0] a_sr, b_sr, c_sr;
  logic                 a_d1, a_d2, b_d1, c_d1;
  logic [2:0]           carry;
  logic [CNT_BITS-1:0]  count;
  logic [3:0]           bit_sum;

  // bit k: a[k-2] + b[k] + b[k-1] + c[k] + c[k-1] + carry
  always_comb begin
    bit_sum = 4'(a_d2) + 4'(b_sr[0]) + 4'(b_d1) + 4'(c_sr[0]) + 4'(c_d1) + 4'(carry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      count  <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        count       <= '0;
      end else if (status.busy) begin
        if (count == LAST) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sr  <= i0;
      b_sr  <= i1;
      c_sr  <= i2;
      a_d1  <= 1'b0;
      a_d2  <= 1'b0;
      b_d1  <= 1'b0;
      c_d1  <= 1'b0;
      carry <= '0;
    end else if (status.busy) begin
      a_sr    <= a_sr >> 1;
      b_sr    <= b_sr >> 1;
      c_sr    <= c_sr >> 1;
      a_d1    <= a_sr[0];
      a_d2    <= a_d1;
      b_d1    <= b_sr[0];
      c_d1    <= c_sr[0];
      carry   <= bit_sum[3:1];
      divisor <= {bit_sum[0], divisor[DIV_BITS-1:1]};
    end
  end

endmodule

[src/prbd_div.sv]
// restoring divider, one quotient bit per cycle, saturated rate out
module prbd_div import prbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_BITS-1:0]  divisor,
  output logic [RATE_BITS-1:0] rate,
  output unit_status_t         status
);

  localparam int CNT_BITS = $clog2(NUM_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(NUM_BITS - 1);

  logic [NUM_BITS-1:0] num_sr;
  logic [NUM_BITS-1:0] rem;
  logic [NUM_BITS-1:0] quot;
  logic [CNT_BITS-1:0] count;
  logic [NUM_BITS-1:0] trial;
  logic                fits;

  // remainder never exceeds the numerator prefix, so its top bit shifts out as zero
  always_comb begin
    trial = {rem[NUM_BITS-2:0], num_sr[NUM_BITS-1]};
    fits  = DIV_BITS'(trial) >= divisor;
    // a zero divisor gives an all-ones quotient, which saturates here too
    rate  = (quot > NUM_BITS'(RATE_MAX)) ? RATE_MAX : quot[RATE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      count  <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        count       <= '0;
      end else if (status.busy) begin
        if (count == LAST) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sr <= RATE_NUMERATOR;
      rem    <= '0;
      quot   <= '0;
    end else if (status.busy) begin
      num_sr <= num_sr << 1;
      rem    <= fits ? trial - divisor[NUM_BITS-1:0] : trial;
      quot   <= {quot[NUM_BITS-2:0], fits};
    end
  end

endmodule
